@@ rtl/rpdsc_pkg.sv @@
package rpdsc_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned COUNT_WIDTH_DEF  = 16;
  localparam int unsigned SAMPLE_WIDTH_DEF = 10;

  // Fixed field widths.
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned THRESH_W = 10;
  localparam int unsigned DUTY_W   = 7;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_IDEAL_PERIOD     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_SLACK     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DARK_THRESHOLD   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BRIGHT_THRESHOLD = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DUTY_MAX         = 3'd4;

  // Reset values.
  localparam logic [PERIOD_W-1:0] IDEAL_PERIOD_RST     = 16'd83;
  localparam logic [PERIOD_W-1:0] PERIOD_SLACK_RST     = 16'd10;
  localparam logic [THRESH_W-1:0] DARK_THRESHOLD_RST   = 10'd130;
  localparam logic [THRESH_W-1:0] BRIGHT_THRESHOLD_RST = 10'd110;
  localparam logic [DUTY_W-1:0]   DUTY_MAX_RST         = 7'd100;
  localparam logic [DUTY_W-1:0]   DUTY_RST             = 7'd100;

  // Input word opcodes.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic [PERIOD_W-1:0] ideal_period;
    logic [PERIOD_W-1:0] period_slack;
    logic [THRESH_W-1:0] dark_threshold;
    logic [THRESH_W-1:0] bright_threshold;
    logic [DUTY_W-1:0]   duty_max;
  } cfg_t;

  // Controller state apart from the tick counter.
  typedef struct packed {
    logic                armed;
    logic [DUTY_W-1:0]   duty;
    logic [PERIOD_W-1:0] last_period;
    logic                last_in_band;
  } state_t;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic [PERIOD_W-1:0] period;
    logic                period_done;
    logic                in_band;
  } res_t;

endpackage

@@ rtl/rpdsc_step.sv @@
module rpdsc_step
  import rpdsc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  cfg_t                    cfg_i,
  input  logic                    opcode_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  state_t                  state_i,
  input  logic [COUNT_WIDTH-1:0]  elapsed_i,
  output state_t                  state_o,
  output logic [COUNT_WIDTH-1:0]  elapsed_o,
  output res_t                    res_o
);

  localparam int unsigned SW = (SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W;
  localparam int unsigned PW = (COUNT_WIDTH > PERIOD_W + 1) ? COUNT_WIDTH : PERIOD_W + 1;

  logic [SW-1:0]       sample_ext;
  logic                blocked;
  logic                done;
  logic [PW-1:0]       per_ext;
  logic [PERIOD_W:0]   upper;
  logic                lower_ok;
  logic [PERIOD_W-1:0] lower;
  logic                too_slow;
  logic                too_fast;
  logic [PERIOD_W-1:0] per_sat;
  logic [DUTY_W:0]     duty_inc;
  logic [DUTY_W-1:0]   duty_up;
  logic [DUTY_W-1:0]   duty_dec;
  logic [DUTY_W-1:0]   duty_down;

  assign sample_ext = SW'(sample_i);
  assign blocked    = (sample_ext > SW'(cfg_i.dark_threshold)) ||
                      (sample_ext < SW'(cfg_i.bright_threshold));
  assign done       = (opcode_i == OP_SAMPLE) && !blocked && state_i.armed;

  // The deadband decision sees the full count, the reported period saturates.
  assign per_ext  = PW'(elapsed_i);
  assign upper    = {1'b0, cfg_i.ideal_period} + {1'b0, cfg_i.period_slack};
  assign lower_ok = cfg_i.ideal_period >= cfg_i.period_slack;
  assign lower    = cfg_i.ideal_period - cfg_i.period_slack;
  assign too_slow = per_ext > PW'(upper);
  assign too_fast = lower_ok && (per_ext < PW'(lower));
  assign per_sat  = (per_ext > PW'({PERIOD_W{1'b1}})) ? {PERIOD_W{1'b1}}
                                                       : per_ext[PERIOD_W-1:0];

  assign duty_inc  = {1'b0, state_i.duty} + {{DUTY_W{1'b0}}, 1'b1};
  assign duty_up   = (duty_inc > {1'b0, cfg_i.duty_max}) ? cfg_i.duty_max
                                                          : duty_inc[DUTY_W-1:0];
  assign duty_dec  = (state_i.duty != '0) ? state_i.duty - {{(DUTY_W-1){1'b0}}, 1'b1}
                                          : '0;
  assign duty_down = (duty_dec > cfg_i.duty_max) ? cfg_i.duty_max : duty_dec;

  always_comb begin
    state_o   = state_i;
    elapsed_o = elapsed_i;
    if (opcode_i == OP_TICK) begin
      if (elapsed_i != '1) begin
        elapsed_o = elapsed_i + COUNT_WIDTH'(1);
      end
    end else if (blocked) begin
      state_o.armed = 1'b1;
    end else if (state_i.armed) begin
      state_o.armed        = 1'b0;
      elapsed_o            = '0;
      state_o.last_period  = per_sat;
      state_o.last_in_band = 1'b0;
      if (too_slow) begin
        state_o.duty = duty_up;
      end else if (too_fast) begin
        state_o.duty = duty_down;
      end else begin
        state_o.last_in_band = 1'b1;
      end
    end
  end

  assign res_o.duty        = state_o.duty;
  assign res_o.period      = state_o.last_period;
  assign res_o.period_done = done;
  assign res_o.in_band     = state_o.last_in_band;

endmodule

@@ rtl/rotor_period_deadband_speed_control.sv @@
// Stages: an accepted word is held in the input register and moves into the result
// register when that register is empty or being drained; a stalled result holds it back.
// Throughput: one word per cycle while results drain; a stall fills the input register.
// Reset: asynchronous, active low; clears both stages, the detector, the tick
// counter, the last period and band flag, loads duty 100 and the register defaults.
module rotor_period_deadband_speed_control
  import rpdsc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    opcode_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DUTY_W-1:0]       duty_o,
  output logic [PERIOD_W-1:0]     period_o,
  output logic                    period_done_o,
  output logic                    in_band_o
);

  cfg_t                    cfg_q;
  logic                    s1_valid_q;
  logic                    s1_opcode_q;
  logic [SAMPLE_WIDTH-1:0] s1_sample_q;
  state_t                  state_q, state_d;
  logic [COUNT_WIDTH-1:0]  elapsed_q, elapsed_d;
  logic                    out_valid_q;
  res_t                    res_q, res_d;
  logic                    advance;
  logic                    load;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ideal_period     <= IDEAL_PERIOD_RST;
      cfg_q.period_slack     <= PERIOD_SLACK_RST;
      cfg_q.dark_threshold   <= DARK_THRESHOLD_RST;
      cfg_q.bright_threshold <= BRIGHT_THRESHOLD_RST;
      cfg_q.duty_max         <= DUTY_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_IDEAL_PERIOD:     cfg_q.ideal_period     <= cfg_wdata_i;
        REG_PERIOD_SLACK:     cfg_q.period_slack     <= cfg_wdata_i;
        REG_DARK_THRESHOLD:   cfg_q.dark_threshold   <= cfg_wdata_i[THRESH_W-1:0];
        REG_BRIGHT_THRESHOLD: cfg_q.bright_threshold <= cfg_wdata_i[THRESH_W-1:0];
        REG_DUTY_MAX:         cfg_q.duty_max         <= cfg_wdata_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // The result register takes a new word when it is empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign load       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_opcode_q <= opcode_i;
      s1_sample_q <= sample_i;
    end
  end

  rpdsc_step #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_step (
    .cfg_i     (cfg_q),
    .opcode_i  (s1_opcode_q),
    .sample_i  (s1_sample_q),
    .state_i   (state_q),
    .elapsed_i (elapsed_q),
    .state_o   (state_d),
    .elapsed_o (elapsed_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.armed        <= 1'b0;
      state_q.duty         <= DUTY_RST;
      state_q.last_period  <= '0;
      state_q.last_in_band <= 1'b0;
      elapsed_q            <= '0;
    end else if (load) begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign duty_o        = res_q.duty;
  assign period_o      = res_q.period;
  assign period_done_o = res_q.period_done;
  assign in_band_o     = res_q.in_band;

  // A held input word must not change while the result register is blocked.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_opcode_q) && $stable(s1_sample_q))
    else $error("input stage changed while stalled");

  // A completed revolution restarts the counter and disarms the detector.
  a_rev_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && res_d.period_done |=> elapsed_q == '0 && !state_q.armed)
    else $error("revolution did not restart the counter");

  // A pending result always matches the controller state it was taken from.
  a_res_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_o == state_q.duty && period_o == state_q.last_period &&
                    in_band_o == state_q.last_in_band)
    else $error("result word out of step with controller state");

endmodule
